>>> rtl/tks_pkg.sv
package tks_pkg;

  // Default sizes, handed to the top level parameters
  localparam int unsigned ENTRIES_DEF  = 1024;
  localparam int unsigned KEEP_MAX_DEF = 64;

  // Fixed field widths
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned ID_W    = 22;
  localparam int unsigned RANK_W  = 6;
  localparam int unsigned KEEP_W  = 7;

  localparam logic [KEEP_W-1:0] KEEP_RST = 7'd8;

  // Depth of the queue between front and back
  localparam int unsigned Q_DEPTH = 2;

  // One classified item as it travels from front to back
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
    logic               last;  // closes the set
    logic               drop;  // store was full, do not write
    logic               ovf;   // some item of this set was dropped so far
  } cmd_t;

  // Selection engine states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_SWAP1,
    ST_SWAP2
  } state_e;

endpackage

>>> rtl/tks_front.sv
module tks_front #(
  parameter int unsigned ENTRIES = tks_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tks_pkg::SCORE_W-1:0] score_i,
  input  logic [tks_pkg::ID_W-1:0]    entry_id_i,
  input  logic                        is_last_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output tks_pkg::cmd_t               cmd_o
);

  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          xfer;
  logic          drop;

  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = in_valid_i;
  assign xfer        = in_valid_i && cmd_ready_i;

  // Classify: an item that finds the store full is dropped
  assign drop = (count_q == CW'(ENTRIES));

  always_comb begin
    cmd_o.score = score_i;
    cmd_o.id    = entry_id_i;
    cmd_o.last  = is_last_i;
    cmd_o.drop  = drop;
    cmd_o.ovf   = ovf_q | drop;
  end

  // Occupancy tracking, restarted after the last item of a set
  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (xfer) begin
      if (is_last_i) begin
        count_d = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = drop ? count_q : count_q + CW'(1);
        ovf_d   = ovf_q | drop;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

>>> rtl/tks_fifo.sv
module tks_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  tks_pkg::cmd_t push_data_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output tks_pkg::cmd_t pop_data_o
);

  localparam int unsigned PW = (tks_pkg::Q_DEPTH > 1) ? $clog2(tks_pkg::Q_DEPTH) : 1;
  localparam int unsigned NW = $clog2(tks_pkg::Q_DEPTH + 1);

  tks_pkg::cmd_t mem_q [tks_pkg::Q_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [NW-1:0] fill_q;
  logic          push, pop;

  assign push_ready_o = (fill_q != NW'(tks_pkg::Q_DEPTH));
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(tks_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(tks_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + NW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - NW'(1);
      end
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> rtl/tks_back.sv
module tks_back #(
  parameter int unsigned ENTRIES  = tks_pkg::ENTRIES_DEF,
  parameter int unsigned KEEP_MAX = tks_pkg::KEEP_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  tks_pkg::cmd_t               cmd_i,
  input  logic [tks_pkg::KEEP_W-1:0]  keep_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tks_pkg::SCORE_W-1:0] top_score_o,
  output logic [tks_pkg::ID_W-1:0]    top_id_o,
  output logic [tks_pkg::RANK_W-1:0]  rank_o,
  output logic                        overflowed_o,
  output logic                        final_result_o,
  output logic                        busy_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned KW = tks_pkg::KEEP_W;
  localparam int unsigned MW = (CW > KW) ? CW : KW;

  // Stores
  logic [tks_pkg::SCORE_W-1:0] score_mem [ENTRIES];
  logic [tks_pkg::ID_W-1:0]    id_mem    [ENTRIES];
  logic [AW-1:0]               perm_mem  [ENTRIES];

  tks_pkg::state_e state_q, state_d;

  logic [CW-1:0] cnt_q, n_q, j_q;
  logic [KW-1:0] k_q, i_q;
  logic          ovf_q;

  // Scan pipeline
  logic          v1_q, v2_q, first1_q, first2_q;
  logic [AW-1:0] pos1_q, pos2_q, ent2_q;
  logic [AW-1:0] perm_rdata_q;
  logic [tks_pkg::SCORE_W-1:0] score_rdata_q;
  logic [tks_pkg::ID_W-1:0]    id_rdata_q;

  // Running maximum of the current pass
  logic [tks_pkg::SCORE_W-1:0] best_val_q;
  logic [AW-1:0]               best_pos_q, best_ent_q, perm_i_q;

  // Output register
  logic                        out_valid_q;
  logic [tks_pkg::SCORE_W-1:0] out_score_q;
  logic [tks_pkg::ID_W-1:0]    out_id_q;
  logic [tks_pkg::RANK_W-1:0]  out_rank_q;
  logic                        out_ovf_q, out_final_q;

  logic          cmd_xfer, load_we, perm_we, out_load, out_free;
  logic          issuing, scan_done, last_rank, take;
  logic [AW-1:0] perm_waddr, perm_wdata;
  logic [CW-1:0] n_new;
  logic [KW-1:0] k_cap, k_sel;

  assign cmd_xfer  = cmd_valid_i && cmd_ready_o;
  assign load_we   = cmd_xfer && !cmd_i.drop;
  assign n_new     = cmd_i.drop ? cnt_q : cnt_q + CW'(1);
  assign issuing   = (j_q < n_q);
  assign scan_done = !issuing && !v1_q && !v2_q;
  assign out_free  = !out_valid_q || out_ready_i;
  assign last_rank = ((i_q + KW'(1)) == k_q);
  assign take      = v2_q && (first2_q || (score_rdata_q > best_val_q));

  // K clipped to KEEP_MAX and to the number of entries held
  always_comb begin
    k_cap = (keep_i > KW'(KEEP_MAX)) ? KW'(KEEP_MAX) : keep_i;
    k_sel = (MW'(k_cap) > MW'(n_new)) ? KW'(n_new) : k_cap;
  end

  // Sequencer: load, then per rank scan, swap and emit
  always_comb begin
    state_d     = state_q;
    cmd_ready_o = 1'b0;
    perm_we     = 1'b0;
    perm_waddr  = cnt_q[AW-1:0];
    perm_wdata  = cnt_q[AW-1:0];
    out_load    = 1'b0;
    unique case (state_q)
      tks_pkg::ST_LOAD: begin
        cmd_ready_o = 1'b1;
        perm_we     = load_we;
        if (cmd_xfer && cmd_i.last && (k_sel != '0)) begin
          state_d = tks_pkg::ST_SCAN;
        end
      end
      tks_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = tks_pkg::ST_SWAP1;
        end
      end
      tks_pkg::ST_SWAP1: begin
        perm_we    = 1'b1;
        perm_waddr = AW'(i_q);
        perm_wdata = best_ent_q;
        state_d    = tks_pkg::ST_SWAP2;
      end
      tks_pkg::ST_SWAP2: begin
        // second half of the swap; rewriting it while stalled is harmless
        perm_we    = 1'b1;
        perm_waddr = best_pos_q;
        perm_wdata = perm_i_q;
        if (out_free) begin
          out_load = 1'b1;
          state_d  = last_rank ? tks_pkg::ST_LOAD : tks_pkg::ST_SCAN;
        end
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tks_pkg::ST_LOAD;
      cnt_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= (state_q == tks_pkg::ST_SCAN) && issuing;
      v2_q    <= v1_q;
      if (cmd_xfer) begin
        cnt_q <= cmd_i.last ? '0 : n_new;
        if (cmd_i.last) begin
          n_q <= n_new;
          k_q <= k_sel;
          i_q <= '0;
          j_q <= '0;
        end
      end
      if ((state_q == tks_pkg::ST_SCAN) && issuing) begin
        j_q <= j_q + CW'(1);
      end
      if (out_load) begin
        i_q <= i_q + KW'(1);
        j_q <= CW'(i_q) + CW'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_xfer && cmd_i.last) begin
      ovf_q <= cmd_i.ovf;
    end
    pos1_q   <= j_q[AW-1:0];
    first1_q <= (j_q == CW'(i_q));
    first2_q <= first1_q;
    pos2_q   <= pos1_q;
    ent2_q   <= perm_rdata_q;
    // only a strictly greater score displaces the current maximum
    if (take) begin
      best_val_q <= score_rdata_q;
      best_pos_q <= pos2_q;
      best_ent_q <= ent2_q;
    end
    if (v2_q && first2_q) begin
      perm_i_q <= ent2_q;
    end
    if (out_load) begin
      out_score_q <= best_val_q;
      out_id_q    <= id_rdata_q;
      out_rank_q  <= i_q[tks_pkg::RANK_W-1:0];
      out_ovf_q   <= ovf_q;
      out_final_q <= last_rank;
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (load_we) begin
      score_mem[cnt_q[AW-1:0]] <= cmd_i.score;
      id_mem[cnt_q[AW-1:0]]    <= cmd_i.id;
    end
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    perm_rdata_q  <= perm_mem[j_q[AW-1:0]];
    score_rdata_q <= score_mem[perm_rdata_q];
    id_rdata_q    <= id_mem[best_ent_q];
  end

  assign out_valid_o    = out_valid_q;
  assign top_score_o    = out_score_q;
  assign top_id_o       = out_id_q;
  assign rank_o         = out_rank_q;
  assign overflowed_o   = out_ovf_q;
  assign final_result_o = out_final_q;
  assign busy_o         = (state_q != tks_pkg::ST_LOAD);

endmodule

>>> rtl/top_k_selector.sv
// Top-K selector.
// Input channel (in_valid_i/in_ready_o): one entry per transfer, a Q16.16
// score and an id; is_last_i closes the set. Entries load at one per cycle
// into the store while the engine is loading; entries beyond ENTRIES
// are dropped and the set's results carry overflowed_o.
// After the last entry, a partial selection sort runs over the n entries
// held: for rank i, positions i to n-1 are scanned one per cycle through
// the single read port of the permutation and score stores (a two-stage
// read pipeline); once it drains, the best entry is swapped into place in
// ST_SWAP1 and ST_SWAP2. Results leave through out_valid_o/out_ready_i
// in descending order, rank 0 first, final_result_o on the last. K is
// count_to_keep (cfg_we_i/cfg_wdata_i, reset 8), clipped to KEEP_MAX and n;
// K of zero gives no result.
// A two-entry queue sits before the selection engine: while results are
// produced, up to two entries of the next set are still taken, then
// in_ready_o drops. A stalled receiver holds the output register and the
// engine waits, nothing is lost.
// Reset clears the counters and control state; the stores need no clearing.
module top_k_selector #(
  parameter int unsigned ENTRIES  = tks_pkg::ENTRIES_DEF,
  parameter int unsigned KEEP_MAX = tks_pkg::KEEP_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tks_pkg::SCORE_W-1:0] score_i,
  input  logic [tks_pkg::ID_W-1:0]    entry_id_i,
  input  logic                        is_last_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tks_pkg::SCORE_W-1:0] top_score_o,
  output logic [tks_pkg::ID_W-1:0]    top_id_o,
  output logic [tks_pkg::RANK_W-1:0]  rank_o,
  output logic                        overflowed_o,
  output logic                        final_result_o,
  input  logic                        cfg_we_i,
  input  logic [tks_pkg::KEEP_W-1:0]  cfg_wdata_i
);

  logic [tks_pkg::KEEP_W-1:0] keep_q;
  logic                       f_valid, f_ready, b_valid, b_ready, busy;
  tks_pkg::cmd_t              f_cmd, b_cmd;

  // count_to_keep register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= tks_pkg::KEEP_RST;
    end else if (cfg_we_i) begin
      keep_q <= cfg_wdata_i;
    end
  end

  tks_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .score_i     (score_i),
    .entry_id_i  (entry_id_i),
    .is_last_i   (is_last_i),
    .cmd_valid_o (f_valid),
    .cmd_ready_i (f_ready),
    .cmd_o       (f_cmd)
  );

  tks_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_data_i  (f_cmd),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_data_o   (b_cmd)
  );

  tks_back #(
    .ENTRIES  (ENTRIES),
    .KEEP_MAX (KEEP_MAX)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (b_valid),
    .cmd_ready_o    (b_ready),
    .cmd_i          (b_cmd),
    .keep_i         (keep_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_score_o    (top_score_o),
    .top_id_o       (top_id_o),
    .rank_o         (rank_o),
    .overflowed_o   (overflowed_o),
    .final_result_o (final_result_o),
    .busy_o         (busy)
  );

  // A result that is not the last one means selection is still running
  a_busy_while_partial: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !final_result_o |-> busy)
    else $error("partial result shown while selection engine is idle");

  // Ranks within a set advance by one
  a_rank_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !final_result_o |=>
      !out_valid_o || (rank_o == tks_pkg::RANK_W'($past(rank_o) + 1'b1)))
    else $error("rank did not advance by one");

  // Overflow flag is constant across one set's results
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !final_result_o |=>
      !out_valid_o || (overflowed_o == $past(overflowed_o)))
    else $error("overflow flag changed within a set");

endmodule

>>> tb/tb_top_k_selector.sv
`timescale 1ns / 100ps

module tb_top_k_selector;

  localparam int unsigned ENTRIES     = tks_pkg::ENTRIES_DEF;
  localparam int unsigned KEEP_MAX    = tks_pkg::KEEP_MAX_DEF;
  localparam int unsigned SCORE_W     = tks_pkg::SCORE_W;
  localparam int unsigned ID_W        = tks_pkg::ID_W;
  localparam int unsigned RANK_W      = tks_pkg::RANK_W;
  localparam int unsigned KEEP_W      = tks_pkg::KEEP_W;
  // quiet time before a register write: covers a full scan of an idle engine
  localparam int unsigned SETTLE_CYC  = ENTRIES + 2 * KEEP_MAX + 16;
  // longest gap allowed between transfers, above a full-store scan and the pre-write quiet
  localparam int unsigned STALL_LIMIT = 20000;

  // one selected entry as it leaves the block
  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic [ID_W-1:0]    id;
    logic [RANK_W-1:0]  rank;
    logic               ovf;
    logic               fin;
  } pick_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SCORE_W-1:0] score_i;
  logic [ID_W-1:0]    entry_id_i;
  logic               is_last_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SCORE_W-1:0] top_score_o;
  logic [ID_W-1:0]    top_id_o;
  logic [RANK_W-1:0]  rank_o;
  logic               overflowed_o;
  logic               final_result_o;
  logic               cfg_we_i;
  logic [KEEP_W-1:0]  cfg_wdata_i;

  top_k_selector uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .score_i        (score_i),
    .entry_id_i     (entry_id_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .top_score_o    (top_score_o),
    .top_id_o       (top_id_o),
    .rank_o         (rank_o),
    .overflowed_o   (overflowed_o),
    .final_result_o (final_result_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // predictor state: the entries held for the current set
  logic [SCORE_W-1:0] held_score [ENTRIES];
  logic [ID_W-1:0]    held_id    [ENTRIES];
  int unsigned        slot_order [ENTRIES];
  int unsigned        held_count;
  logic               held_ovf;
  logic [KEEP_W-1:0]  keep_cfg;

  pick_t       picks_due[$];
  int unsigned mismatches;
  bit          calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // adds an entry; after the last, partial selection sort queues the ranked picks
  function automatic void predict_entry(input logic [SCORE_W-1:0] sc,
                                        input logic [ID_W-1:0] id, input logic last);
    int unsigned        n;
    int unsigned        k;
    int unsigned        best;
    int unsigned        swap;
    logic [SCORE_W-1:0] best_val;
    pick_t              p;
    if (held_count < ENTRIES) begin
      held_score[held_count] = sc;
      held_id[held_count]    = id;
      held_count++;
    end else begin
      held_ovf = 1'b1;
    end
    if (!last) return;
    n = held_count;
    k = keep_cfg;
    if (k > KEEP_MAX) k = KEEP_MAX;
    if (k > n) k = n;
    for (int unsigned i = 0; i < n; i++) slot_order[i] = i;
    for (int unsigned i = 0; i < k; i++) begin
      best     = i;
      best_val = held_score[slot_order[i]];
      // only a strictly greater score takes over, so ties keep the earlier slot
      for (int unsigned j = i + 1; j < n; j++) begin
        if (held_score[slot_order[j]] > best_val) begin
          best     = j;
          best_val = held_score[slot_order[j]];
        end
      end
      swap             = slot_order[i];
      slot_order[i]    = slot_order[best];
      slot_order[best] = swap;
    end
    for (int unsigned i = 0; i < k; i++) begin
      p.score = held_score[slot_order[i]];
      p.id    = held_id[slot_order[i]];
      p.rank  = RANK_W'(i);
      p.ovf   = held_ovf;
      p.fin   = (i + 1 == k);
      picks_due.push_back(p);
    end
    held_count = 0;
    held_ovf   = 1'b0;
  endfunction

  function automatic logic [SCORE_W-1:0] draw_score();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return SCORE_W'($urandom_range(0, 7));  // dense range, many ties
      default: return SCORE_W'($urandom());
    endcase
  endfunction

  function automatic logic [ID_W-1:0] draw_id();
    return ID_W'($urandom());
  endfunction

  task automatic report_bad(input string what, input pick_t due, input pick_t got);
    if (mismatches < 10) begin
      $display("%0t %s: exp score=%h id=%h rank=%0d ovf=%b fin=%b", $realtime, what,
               due.score, due.id, due.rank, due.ovf, due.fin);
      $display("%0t %s: got score=%h id=%h rank=%0d ovf=%b fin=%b", $realtime, what,
               got.score, got.id, got.rank, got.ovf, got.fin);
    end
    mismatches++;
  endtask

  // one input transfer, with an occasional gap before it
  task automatic send_entry(input logic [SCORE_W-1:0] sc, input logic [ID_W-1:0] id,
                            input logic last);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    score_i    <= sc;
    entry_id_i <= id;
    is_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_entry(sc, id, last);
  endtask

  task automatic send_set(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_entry(draw_score(), draw_id(), i + 1 == len);
  endtask

  // stop sending and let every queued pick come out
  task automatic wait_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk_i);
  endtask

  // register write, only with the block idle
  task automatic write_keep(input logic [KEEP_W-1:0] v);
    wait_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    keep_cfg = v;
  endtask

  // reset value of K, extremes of every field, ties at top and bottom
  task automatic test_default_keep();
    logic [SCORE_W-1:0] sc [10] = '{32'd5, 32'hFFFF_FFFF, 32'd0, 32'd5, 32'h0001_0000,
                                    32'hFFFF_FFFF, 32'd7, 32'd5, 32'd0, 32'h7FFF_FFFF};
    logic [ID_W-1:0]    ids[10] = '{22'h3F_FFFF, 22'd0, 22'h15_5555, 22'h2A_AAAA, 22'd1,
                                    22'h3F_FFFE, 22'd2, 22'h20_0000, 22'h1F_FFFF, 22'd3};
    for (int i = 0; i < 10; i++) send_entry(sc[i], ids[i], i == 9);
  endtask

  // a set of one entry clips K to one
  task automatic test_single_entry();
    send_entry(32'h8000_0000, 22'h3F_FFFF, 1'b1);
  endtask

  // K of zero: the last entry yields nothing
  task automatic test_keep_zero();
    write_keep(7'd0);
    send_entry(32'd10, 22'd4, 1'b0);
    send_entry(32'd20, 22'd5, 1'b1);
  endtask

  // K beyond KEEP_MAX, clipped down to the set size; all scores equal
  task automatic test_keep_over_max();
    write_keep(7'd127);
    for (int i = 0; i < 3; i++) send_entry(32'h0000_1234, ID_W'(i + 8), i == 2);
  endtask

  // K of one, maximum tied and last in load order
  task automatic test_keep_one();
    write_keep(7'd1);
    send_entry(32'd3, 22'd11, 1'b0);
    send_entry(32'd9, 22'd12, 1'b0);
    send_entry(32'd1, 22'd13, 1'b0);
    send_entry(32'd9, 22'd14, 1'b1);
  endtask

  // store full: extra entries dropped and flagged, the last one among them
  task automatic test_store_full();
    write_keep(7'd64);
    for (int unsigned i = 0; i < ENTRIES + 2; i++) send_entry(draw_score(), draw_id(), 1'b0);
    send_entry(draw_score(), draw_id(), 1'b1);
    // exactly full: nothing dropped, flag cleared from the previous set
    write_keep(7'd3);
    send_set(ENTRIES);
  endtask

  // random sets over several K settings
  task automatic test_random_sets();
    int unsigned   budget;
    int unsigned   len;
    logic [KEEP_W-1:0] keeps [6];
    keeps = '{KEEP_W'($urandom_range(1, 16)), 7'd64, 7'd0, KEEP_W'($urandom_range(65, 127)),
              7'd1, KEEP_W'($urandom_range(2, 12))};
    for (int ph = 0; ph < 6; ph++) begin
      write_keep(keeps[ph]);
      calm = (ph == 5);
      budget = 0;
      while (budget < 25) begin
        len = $urandom_range(0, 5) == 0 ? $urandom_range(13, 40) : $urandom_range(1, 12);
        if (ph == 3 && budget == 0) len = $urandom_range(66, 72);  // n above KEEP_MAX
        send_set(len);
        budget += len;
        // hold off the next set until the results are all out
        if (ph == 1) wait_results();
      end
    end
  endtask

  // receiver stalls in bursts
  initial begin : rx_stall
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // compare each result transfer with the oldest queued pick
  always @(posedge clk_i) begin : result_check
    pick_t got;
    pick_t due;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {top_score_o, top_id_o, rank_o, overflowed_o, final_result_o};
      if (picks_due.size() == 0) begin
        report_bad("unexpected result", got, got);
      end else begin
        due = picks_due.pop_front();
        if (got.score !== due.score || got.id !== due.id || got.rank !== due.rank ||
            got.ovf !== due.ovf || got.fin !== due.fin)
          report_bad("result mismatch", due, got);
      end
    end
  end

  // no transfer for too long ends the run
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("top_k_selector verification failed");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    score_i     = '0;
    entry_id_i  = '0;
    is_last_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    held_count  = 0;
    held_ovf    = 1'b0;
    keep_cfg    = tks_pkg::KEEP_RST;
    mismatches  = 0;
    calm        = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_keep();
    test_single_entry();
    test_keep_zero();
    test_keep_over_max();
    test_keep_one();
    test_store_full();
    test_random_sets();

    wait_results();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("top_k_selector verification clean");
    end else begin
      $display("top_k_selector verification failed");
    end
    $finish;
  end

endmodule
